FILE: hw/rtl/lbs_pkg.sv
// Shared types, constants and fixed-point helpers for the skinning block.
`default_nettype none
package lbs_pkg;

    localparam int POSE_WORDS = 14;
    localparam int SLOT_CUR_POS = 4;
    localparam int SLOT_REST_QUAT = 7;
    localparam int SLOT_REST_POS = 11;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_INFL = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [5:0]       joint;
        logic [16:0]      weight;
        logic             last;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] nrm;
        logic [3:0]       slot;
        logic [31:0]      value;
        logic             ok;
    } t_item;

    function automatic logic signed [63:0] rnd(input logic signed [63:0] p, input int f);
        return (p + (64'sd1 <<< (f - 1))) >>> f;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sd140737488355327) begin
            return {1'b0, {47{1'b1}}};
        end else if (v < -64'sd140737488355328) begin
            return {1'b1, 47'd0};
        end
        return v[47:0];
    endfunction

    function automatic logic signed [63:0] sx(input logic [31:0] a);
        return $signed({{32{a[31]}}, a});
    endfunction

    function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
        return sat32(sx(a) + sx(b));
    endfunction

    function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
        return sat32(sx(a) - sx(b));
    endfunction

    // Quaternion component pairs of the nine rotation products:
    // xx yy zz xy xz yz wx wy wz
    function automatic logic [1:0] quat_a(input logic [3:0] k);
        case (k)
            4'd0, 4'd3, 4'd4: return 2'd0;
            4'd1, 4'd5:       return 2'd1;
            4'd2:             return 2'd2;
            default:          return 2'd3;
        endcase
    endfunction

    function automatic logic [1:0] quat_b(input logic [3:0] k);
        case (k)
            4'd0, 4'd6:       return 2'd0;
            4'd1, 4'd3, 4'd7: return 2'd1;
            default:          return 2'd2;
        endcase
    endfunction

    function automatic logic [31:0] rot_elem(input logic [8:0][31:0] pr,
                                             input logic [3:0] e,
                                             input logic [31:0] one);
        case (e)
            4'd0:    return fsub(one, fadd(fadd(pr[1], pr[2]), fadd(pr[1], pr[2])));
            4'd1:    return fadd(fsub(pr[3], pr[8]), fsub(pr[3], pr[8]));
            4'd2:    return fadd(fadd(pr[4], pr[7]), fadd(pr[4], pr[7]));
            4'd3:    return fadd(fadd(pr[3], pr[8]), fadd(pr[3], pr[8]));
            4'd4:    return fsub(one, fadd(fadd(pr[0], pr[2]), fadd(pr[0], pr[2])));
            4'd5:    return fadd(fsub(pr[5], pr[6]), fsub(pr[5], pr[6]));
            4'd6:    return fadd(fsub(pr[4], pr[7]), fsub(pr[4], pr[7]));
            4'd7:    return fadd(fadd(pr[5], pr[6]), fadd(pr[5], pr[6]));
            4'd8:    return fsub(one, fadd(fadd(pr[0], pr[1]), fadd(pr[0], pr[1])));
            default: return 32'd0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/linear_blend_skinning_top.sv
// Top level of the linear blend skinning block.
`default_nettype none
// Load beats (cmd 0) write one pose word into the joint table and are taken
// while the sequencer stays idle. An influence beat (cmd 1) to a valid joint
// runs through one shared 32x32 multiplier: 14 table reads, 18 rotation
// products, 27 for the combined rotation, 9 for the translation and 12
// weighting products, each phase followed by a pipeline drain, plus the take
// and rebuild steps. A last influence adds 18 products for position and
// normal, their drain and an emit step. A two-entry queue sits between the
// input and the sequencer, and the result waits in an output register while
// the next beat is worked on.
module linear_blend_skinning_top
    import lbs_pkg::*;
#(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_cmd,
    input  wire logic [5:0]         i_joint_index,
    input  wire logic [16:0]        i_weight,
    input  wire logic               i_last_influence,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_nrm_x,
    input  wire logic signed [31:0] i_nrm_y,
    input  wire logic signed [31:0] i_nrm_z,
    input  wire logic [3:0]         i_pose_slot,
    input  wire logic signed [31:0] i_pose_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_out_pos_x,
    output logic signed [31:0]      o_out_pos_y,
    output logic signed [31:0]      o_out_pos_z,
    output logic signed [31:0]      o_out_nrm_x,
    output logic signed [31:0]      o_out_nrm_y,
    output logic signed [31:0]      o_out_nrm_z
);

    logic             q_valid;
    t_item            q_item;
    logic             q_pop;
    logic [5:0][31:0] res;

    lbs_front #(
        .MAX_JOINTS(MAX_JOINTS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_joint_index   (i_joint_index),
        .i_weight        (i_weight),
        .i_last_influence(i_last_influence),
        .i_pos           ({i_pos_z, i_pos_y, i_pos_x}),
        .i_nrm           ({i_nrm_z, i_nrm_y, i_nrm_x}),
        .i_pose_slot     (i_pose_slot),
        .i_pose_value    (i_pose_value),
        .o_q_valid       (q_valid),
        .o_q_item        (q_item),
        .i_q_pop         (q_pop)
    );

    lbs_back #(
        .MAX_JOINTS(MAX_JOINTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_item (q_item),
        .o_q_pop  (q_pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (res)
    );

    assign o_out_pos_x = $signed(res[0]);
    assign o_out_pos_y = $signed(res[1]);
    assign o_out_pos_z = $signed(res[2]);
    assign o_out_nrm_x = $signed(res[3]);
    assign o_out_nrm_y = $signed(res[4]);
    assign o_out_nrm_z = $signed(res[5]);

endmodule
`default_nettype wire

FILE: hw/rtl/lbs_front.sv
// Front end: takes input beats, classifies them and queues them for the back end.
`default_nettype none
module lbs_front
    import lbs_pkg::*;
#(
    parameter int MAX_JOINTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_cmd,
    input  wire logic [5:0]  i_joint_index,
    input  wire logic [16:0] i_weight,
    input  wire logic        i_last_influence,
    input  wire logic [2:0][31:0] i_pos,
    input  wire logic [2:0][31:0] i_nrm,
    input  wire logic [3:0]  i_pose_slot,
    input  wire logic [31:0] i_pose_value,
    output logic             o_q_valid,
    output t_item            o_q_item,
    input  wire logic        i_q_pop
);

    t_item      r_buf [2];
    logic [1:0] r_cnt;
    logic       r_wp;
    logic       r_rp;
    t_item      n_item;
    logic       push;
    logic       joint_ok;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_buf[r_rp];
    assign joint_ok  = (32'(i_joint_index) < MAX_JOINTS);

    always_comb begin
        n_item.cmd    = i_cmd;
        n_item.joint  = i_joint_index;
        n_item.weight = i_weight;
        n_item.last   = i_last_influence;
        n_item.pos    = i_pos;
        n_item.nrm    = i_nrm;
        n_item.slot   = i_pose_slot;
        n_item.value  = i_pose_value;
        // mark as not ok: loads to a missing joint or an unused slot, influences to a missing joint
        if (i_cmd == CMD_LOAD) begin
            n_item.ok = joint_ok && (32'(i_pose_slot) < POSE_WORDS);
        end else begin
            n_item.ok = joint_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (push) begin
                r_buf[r_wp] <= n_item;
                r_wp        <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hw/rtl/lbs_back.sv
// Back end: joint table, shared multiplier sequencer, blend accumulator, output register.
`default_nettype none
module lbs_back
    import lbs_pkg::*;
#(
    parameter int MAX_JOINTS = 64,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire logic  i_stall,
    output logic [5:0][31:0] o_res
);

    localparam int MEM_DEPTH = MAX_JOINTS * POSE_WORDS;
    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ROT, S_RBLD, S_A, S_T, S_W, S_OUT, S_FIN
    } t_state;

    logic [31:0]             mem [MEM_DEPTH];
    logic [31:0]             r_rdata;
    t_state                  r_state;
    t_item                   r_item;
    logic                    r_iss;
    logic                    r_cv;
    logic [3:0]              r_c0, r_cc0;
    logic [1:0]              r_c1, r_cc1;
    logic [1:0]              r_c2, r_cc2;
    logic signed [63:0]      r_prod;
    logic [31:0]             r_pw [POSE_WORDS];
    logic [1:0][8:0][31:0]   r_pr;
    logic [31:0]             r_rot [2][9];
    logic [31:0]             r_a [3][3];
    logic [31:0]             r_t [3];
    logic [31:0]             r_sum;
    logic signed [47:0]      r_acc [3][4];
    logic [31:0]             r_ps [3];
    logic [31:0]             r_ns [3];
    logic                    r_ovalid;
    logic [5:0][31:0]        r_res;

    logic signed [31:0]      op_a;
    logic signed [31:0]      op_b;
    logic [3:0]              lim0;
    logic [1:0]              lim1;
    logic [1:0]              lim2;
    logic [AW-1:0]           raddr;
    logic [AW-1:0]           waddr;
    logic                    we;
    logic [31:0]             res32;
    logic signed [63:0]      resw;
    logic                    out_free;
    logic [3:0]              pidx;
    logic [31:0]             sum_nx;

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign we       = o_q_pop && (i_q_item.cmd == CMD_LOAD) && i_q_item.ok;
    assign waddr    = AW'(32'(i_q_item.joint) * POSE_WORDS + 32'(i_q_item.slot));
    assign raddr    = AW'(32'(r_item.joint) * POSE_WORDS + 32'(r_c0));
    assign resw     = rnd(r_prod, FRAC_BITS);
    assign res32    = sat32(resw);
    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_res    = r_res;
    assign sum_nx   = (r_cc0 == 4'd0) ? res32 : fadd(r_sum, res32);

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= i_q_item.value;
        end
        r_rdata <= mem[raddr];
    end

    // odometer limits (last value of each counter) per phase
    always_comb begin
        lim0 = 4'd0;
        lim1 = 2'd0;
        lim2 = 2'd0;
        case (r_state)
            S_LOAD: lim0 = 4'(POSE_WORDS - 1);
            S_ROT: begin
                lim0 = 4'd8;
                lim1 = 2'd1;
            end
            S_A: begin
                lim0 = 4'd2;
                lim1 = 2'd2;
                lim2 = 2'd2;
            end
            S_T: begin
                lim0 = 4'd2;
                lim1 = 2'd2;
            end
            S_W: begin
                lim0 = 4'd3;
                lim1 = 2'd2;
            end
            S_OUT: begin
                lim0 = 4'd1;
                lim1 = 2'd2;
                lim2 = 2'd2;
            end
            default: lim0 = 4'd0;
        endcase
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        pidx = (r_c1[0] ? 4'(SLOT_REST_QUAT) : 4'd0);
        case (r_state)
            S_ROT: begin
                op_a = $signed(r_pw[pidx + 4'(quat_a(r_c0))]);
                op_b = $signed(r_pw[pidx + 4'(quat_b(r_c0))]);
            end
            S_A: begin
                op_a = $signed(r_rot[0][4'(r_c2) * 4'd3 + r_c0]);
                op_b = $signed(r_rot[1][4'(r_c1) * 4'd3 + r_c0]);
            end
            S_T: begin
                op_a = $signed(r_a[r_c1][r_c0[1:0]]);
                op_b = $signed(r_pw[4'(SLOT_REST_POS) + r_c0]);
            end
            S_W: begin
                op_a = $signed({15'd0, r_item.weight});
                op_b = (r_c0 == 4'd3) ? $signed(r_t[r_c1]) : $signed(r_a[r_c1][r_c0[1:0]]);
            end
            S_OUT: begin
                op_a = $signed(sat32(64'(r_acc[r_c2][r_c1])));
                op_b = r_c0[0] ? $signed(r_item.nrm[r_c1]) : $signed(r_item.pos[r_c1]);
            end
            default: op_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_iss    <= 1'b0;
            r_cv     <= 1'b0;
            r_c0     <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r_acc[i][j] <= '0;
                end
            end
        end else begin
            r_prod <= op_a * op_b;
            r_cv   <= r_iss;
            r_cc0  <= r_c0;
            r_cc1  <= r_c1;
            r_cc2  <= r_c2;

            // retire the product issued last cycle
            if (r_cv) begin
                case (r_state)
                    S_LOAD: r_pw[r_cc0] <= r_rdata;
                    S_ROT:  r_pr[r_cc1[0]][r_cc0] <= res32;
                    S_A: begin
                        r_sum <= sum_nx;
                        r_a[r_cc2][r_cc1] <= sum_nx;
                    end
                    S_T: begin
                        r_sum <= sum_nx;
                        r_t[r_cc1] <= fsub(r_pw[4'(SLOT_CUR_POS) + 4'(r_cc1)], sum_nx);
                    end
                    S_W: begin
                        r_acc[r_cc1][r_cc0[1:0]] <=
                            sat48(64'(r_acc[r_cc1][r_cc0[1:0]]) + resw);
                    end
                    S_OUT: begin
                        if (r_cc0[0]) begin
                            r_ns[r_cc2] <= (r_cc1 == 2'd0) ? res32 : fadd(r_ns[r_cc2], res32);
                        end else begin
                            r_ps[r_cc2] <= (r_cc1 == 2'd0) ? res32 : fadd(r_ps[r_cc2], res32);
                        end
                    end
                    default: r_sum <= r_sum;
                endcase
            end

            // advance the issue counters
            if (r_iss) begin
                if (r_c0 == lim0) begin
                    r_c0 <= '0;
                    if (r_c1 == lim1) begin
                        r_c1 <= '0;
                        if (r_c2 == lim2) begin
                            r_c2  <= '0;
                            r_iss <= 1'b0;
                        end else begin
                            r_c2 <= r_c2 + 2'd1;
                        end
                    end else begin
                        r_c1 <= r_c1 + 2'd1;
                    end
                end else begin
                    r_c0 <= r_c0 + 4'd1;
                end
            end

            if (r_state == S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_item;
                        if (i_q_item.cmd == CMD_INFL) begin
                            if (i_q_item.ok) begin
                                r_state <= S_LOAD;
                                r_iss   <= 1'b1;
                            end else if (i_q_item.last) begin
                                r_state <= S_OUT;
                                r_iss   <= 1'b1;
                            end
                        end
                    end
                end
                S_RBLD: begin
                    for (int s = 0; s < 2; s++) begin
                        for (int e = 0; e < 9; e++) begin
                            r_rot[s][e] <= rot_elem(r_pr[s], 4'(e), ONE);
                        end
                    end
                    r_state <= S_A;
                    r_iss   <= 1'b1;
                end
                S_FIN: begin
                    if (out_free) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res[i]     <= fadd(r_ps[i], sat32(64'(r_acc[i][3])));
                            r_res[3 + i] <= r_ns[i];
                            for (int j = 0; j < 4; j++) begin
                                r_acc[i][j] <= '0;
                            end
                        end
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    if (!r_iss && !r_cv) begin
                        case (r_state)
                            S_LOAD: begin
                                r_state <= S_ROT;
                                r_iss   <= 1'b1;
                            end
                            S_ROT: r_state <= S_RBLD;
                            S_A: begin
                                r_state <= S_T;
                                r_iss   <= 1'b1;
                            end
                            S_T: begin
                                r_state <= S_W;
                                r_iss   <= 1'b1;
                            end
                            S_W: begin
                                r_state <= r_item.last ? S_OUT : S_IDLE;
                                r_iss   <= r_item.last;
                            end
                            S_OUT:   r_state <= S_FIN;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    a_pop_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && !r_iss && !r_cv))
        else $error("item taken while busy");

    a_fin_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=>
            (r_ovalid && r_acc[0][0] == 48'sd0 && r_acc[2][3] == 48'sd0))
        else $error("accumulator not cleared on emit");

endmodule
`default_nettype wire
